@@ rtl/core/lpht_pkg.sv @@
// Package for the linear-probe hash table: sizes, status and kind codes,
// slot layout, RAM write port and controller states. No dependencies.
package lpht_pkg;

  localparam int SLOTS  = 8;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int KEY_W  = 31;
  localparam int MASK_W = 5;
  localparam int STAT_W = 2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam bit SLOTS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);

  typedef enum logic {
    KIND_RESERVE = 1'b0,
    KIND_INQUIRE = 1'b1
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_STORED  = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_FOUND   = 2'd2,
    STAT_MISSING = 2'd3
  } status_t;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [MASK_W-1:0] mask;
  } slot_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    slot_t            data;
  } ram_wr_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HOME,
    ST_PROBE
  } state_t;

endpackage

@@ rtl/core/lpht_ram.sv @@
// Slot memory of the hash table: one write port, one read port with
// registered read data. Depends on lpht_pkg.
module lpht_ram import lpht_pkg::*; (
  input  logic             clk,
  input  ram_wr_t          wr,
  input  logic [IDX_W-1:0] rd_addr,
  output slot_t            rd_data
);

  slot_t mem [SLOTS];
  slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/lpht_home.sv @@
// Home slot unit: customer id modulo the slot count. Power-of-two tables
// take the low bits into one register; others use a reciprocal multiply, a
// multiply-subtract and one correction step, each registered. Depends on lpht_pkg.
module lpht_home import lpht_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [KEY_W-1:0] id,
  output logic             done,
  output logic [IDX_W-1:0] slot
);

  if (SLOTS_POW2) begin : g_pow2
    logic             done_r;
    logic [IDX_W-1:0] slot_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        done_r <= 1'b0;
      end else begin
        done_r <= start;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        slot_r <= id[IDX_W-1:0];
      end
    end

    assign done = done_r;
    assign slot = slot_r;
  end else begin : g_div
    localparam int REM_W = IDX_W + 1;
    // Truncated reciprocal: the quotient estimate is low by at most one.
    localparam logic [KEY_W-1:0] RECIP   = KEY_W'((64'd1 << KEY_W) / SLOTS);
    localparam logic [KEY_W-1:0] SLOTS_K = KEY_W'(SLOTS);
    localparam logic [REM_W-1:0] SLOTS_R = REM_W'(SLOTS);

    logic               s1_r;
    logic               s2_r;
    logic               done_r;
    logic [KEY_W-1:0]   id_r;
    logic [KEY_W-1:0]   quo_r;
    logic [REM_W-1:0]   diff_r;
    logic [IDX_W-1:0]   slot_r;
    logic [2*KEY_W-1:0] prod;
    logic [IDX_W-1:0]   rem_fix;

    assign prod = (2*KEY_W)'(id) * (2*KEY_W)'(RECIP);

    // Remainder estimate lies below twice the slot count; subtract once if needed.
    always_comb begin
      if (diff_r >= SLOTS_R) begin
        rem_fix = IDX_W'(diff_r - SLOTS_R);
      end else begin
        rem_fix = diff_r[IDX_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s1_r   <= 1'b0;
        s2_r   <= 1'b0;
        done_r <= 1'b0;
      end else begin
        s1_r   <= start;
        s2_r   <= s1_r;
        done_r <= s2_r;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        id_r  <= id;
        quo_r <= prod[2*KEY_W-1:KEY_W];
      end
      if (s1_r) begin
        diff_r <= REM_W'(id_r - quo_r * SLOTS_K);
      end
      if (s2_r) begin
        slot_r <= rem_fix;
      end
    end

    assign done = done_r;
    assign slot = slot_r;
  end

endmodule

@@ rtl/core/linear_probe_hash_table.sv @@
// Top level of the open-addressing hash table with linear probing.
// Holds the probe controller; uses lpht_pkg, lpht_home and lpht_ram.
//
// The result strobe is registered once the probe finishes; P slots are probed
// (1 to SLOTS), one slot read per cycle from lpht_ram, from the home slot on.
// No new item is taken before the strobe; busy drops with the strobe.
// Non-power-of-two slot counts also pass lpht_home's multiply-subtract and
// correction steps. Reset: a clearing pass empties every slot; busy stays high.
module linear_probe_hash_table import lpht_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_kind,
  input  logic [KEY_W-1:0]  in_customer_id,
  input  logic [MASK_W-1:0] in_seat_mask,
  output logic              out_valid,
  output logic [STAT_W-1:0] out_status,
  output logic [MASK_W-1:0] out_found_mask
);

  state_t            state_r, state_nxt;

  // Item held for the whole probe walk.
  kind_t             kind_r;
  logic [KEY_W-1:0]  id_r;
  logic [MASK_W-1:0] mask_r;

  // Probe position and number of slots already passed.
  logic [IDX_W-1:0]  pos_r;
  logic [IDX_W-1:0]  cnt_r;
  logic [IDX_W-1:0]  next_pos;

  // Clearing pass address.
  logic [IDX_W-1:0]  clr_r;

  logic              home_start;
  logic              home_done;
  logic [IDX_W-1:0]  home_slot;

  ram_wr_t           ram_wr;
  logic [IDX_W-1:0]  rd_addr;
  slot_t             rd_slot;

  // Probe decision on the slot just read.
  logic              finish;
  logic              do_store;
  status_t           fin_status;
  logic [MASK_W-1:0] fin_mask;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [MASK_W-1:0] out_found_mask_r;

  lpht_home u_home (
    .clk   (clk),
    .rst_n (rst_n),
    .start (home_start),
    .id    (in_customer_id),
    .done  (home_done),
    .slot  (home_slot)
  );

  lpht_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_slot)
  );

  // Wrap round at the last slot.
  assign next_pos = (pos_r == LAST_IDX) ? '0 : pos_r + IDX_W'(1);

  // Decide on the slot at pos_r, whose data arrives this cycle.
  // Reserve stops at the first empty slot; inquire stops at an empty slot or
  // a matching key, never at a mismatch. Both stop after the last slot.
  always_comb begin
    finish     = 1'b0;
    do_store   = 1'b0;
    fin_status = STAT_MISSING;
    fin_mask   = '0;
    if (kind_r == KIND_RESERVE) begin
      if (!rd_slot.valid) begin
        finish     = 1'b1;
        do_store   = 1'b1;
        fin_status = STAT_STORED;
      end else if (cnt_r == LAST_IDX) begin
        finish     = 1'b1;
        fin_status = STAT_FULL;
      end
    end else begin
      if (!rd_slot.valid) begin
        finish     = 1'b1;
        fin_status = STAT_MISSING;
      end else if (rd_slot.key == id_r) begin
        finish     = 1'b1;
        fin_status = STAT_FOUND;
        fin_mask   = rd_slot.mask;
      end else if (cnt_r == LAST_IDX) begin
        finish     = 1'b1;
        fin_status = STAT_MISSING;
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_HOME;
        end
      end
      ST_HOME: begin
        if (home_done) begin
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Controller outputs: home unit kick, RAM read address and write port.
  always_comb begin
    home_start = 1'b0;
    rd_addr    = pos_r;
    ram_wr     = '0;
    case (state_r)
      ST_CLEAR: begin
        ram_wr.en   = 1'b1;
        ram_wr.addr = clr_r;
        ram_wr.data = '0;
      end
      ST_IDLE: begin
        home_start = start;
      end
      ST_HOME: begin
        // Issue the home-slot read as soon as the remainder is ready.
        rd_addr = home_slot;
      end
      ST_PROBE: begin
        // Read ahead at the next slot so its data is ready when it is probed.
        if (!finish) begin
          rd_addr = next_pos;
        end
        if (do_store) begin
          ram_wr.en         = 1'b1;
          ram_wr.addr       = pos_r;
          ram_wr.data.valid = 1'b1;
          ram_wr.data.key   = id_r;
          ram_wr.data.mask  = mask_r;
        end
      end
      default: begin
        home_start = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_PROBE) && finish;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + IDX_W'(1);
      end
    end
  end

  // Payload and probe position; hold the item while probing.
  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && start) begin
      kind_r <= kind_t'(in_kind);
      id_r   <= in_customer_id;
      mask_r <= in_seat_mask;
    end
    if ((state_r == ST_HOME) && home_done) begin
      pos_r <= home_slot;
      cnt_r <= '0;
    end else if ((state_r == ST_PROBE) && !finish) begin
      pos_r <= next_pos;
      cnt_r <= cnt_r + IDX_W'(1);
    end
    if ((state_r == ST_PROBE) && finish) begin
      out_status_r     <= fin_status;
      out_found_mask_r <= fin_mask;
    end
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_found_mask = out_found_mask_r;

`ifndef SYNTHESIS
  a_strobe_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_PROBE))
    else $error("result strobe without a finished probe");

  a_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr.en |-> (state_r == ST_CLEAR) || (state_r == ST_PROBE))
    else $error("slot write outside clearing pass or probe");

  a_mask_only_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_FOUND) |-> (out_found_mask == '0))
    else $error("nonzero mask on a result other than found");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accepted item did not hold the block busy");

  a_store_empty_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE) && ram_wr.en |-> !rd_slot.valid && (kind_r == KIND_RESERVE))
    else $error("store over an occupied slot");
`endif

endmodule
